FILE: rtl/core/ksat_pkg.sv
package ksat_pkg;

   localparam int DEF_ENTRIES = 32;

   localparam int KEY_W    = 27;
   localparam int AGE_W    = 7;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 5;
   localparam int COUNT_W  = 6;
   localparam int CSR_IDX_W = 2;

   localparam logic [AGE_W-1:0] YOUNG_LIMIT_RESET  = 7'd18;
   localparam logic [AGE_W-1:0] MIDDLE_LIMIT_RESET = 7'd35;

   localparam logic [CSR_IDX_W-1:0] CSR_YOUNG_LIMIT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIDDLE_LIMIT = 2'd1;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DELETE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DUP     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd3;

   typedef enum logic [1:0] {
      BIN_YOUNG,
      BIN_MIDDLE,
      BIN_OLD
   } bin_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic    match;
      bin_type bin;
   } cmp_res_type;

endpackage

FILE: rtl/core/keyed_slot_table_with_age_bins_core.sv
// A result strobes after the scan and write-back of its item; a new item is accepted only
// while idle, and busy falls in the same cycle as the result strobe.
// The single compare/bin unit and the one read port of the key/age memory set the pace:
// ST_SCAN reads one slot per cycle, ST_LAST compares the last one, ST_FINISH writes back.
// Synchronous active-high reset frees every slot and restores both age limits.
// Results are shown for one cycle; the receiver cannot stall them.
module keyed_slot_table_with_age_bins_core
   import ksat_pkg::*;
#(
   parameter int ENTRIES = DEF_ENTRIES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_cmd,
   input  logic [KEY_W-1:0]     req_key,
   input  logic [AGE_W-1:0]     req_age,
   output logic                 rsp_valid,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [SLOT_W-1:0]    rsp_slot,
   output logic [COUNT_W-1:0]   rsp_young_count,
   output logic [COUNT_W-1:0]   rsp_middle_count,
   output logic [COUNT_W-1:0]   rsp_old_count,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [AGE_W-1:0]     csr_wdata
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   state_type state_ff, state_in;

   logic [AGE_W-1:0] young_limit_ff, middle_limit_ff;

   logic [ENTRIES-1:0] used_ff, used_in;

   logic             cmd_ff, cmd_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [AGE_W-1:0] age_ff, age_in;

   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;

   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             hit_found_ff, hit_found_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [AGE_W-1:0] hit_age_ff, hit_age_in;

   logic [CNT_W-1:0] young_cnt_ff, young_cnt_in;
   logic [CNT_W-1:0] middle_cnt_ff, middle_cnt_in;
   logic [CNT_W-1:0] old_cnt_ff, old_cnt_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [COUNT_W-1:0]  rsp_young_ff, rsp_young_in;
   logic [COUNT_W-1:0]  rsp_middle_ff, rsp_middle_in;
   logic [COUNT_W-1:0]  rsp_old_ff, rsp_old_in;

   // sequencer outputs
   logic accept;
   logic scan_en;
   logic finish_en;

   logic             mem_wr_en;
   logic [KEY_W-1:0] mem_rd_key;
   logic [AGE_W-1:0] mem_rd_age;

   logic             cmp_used;
   logic [AGE_W-1:0] cmp_age;
   cmp_res_type      cmp_res;

   logic             ins_done, del_done;
   logic [IDX_W-1:0] res_idx;
   logic [CNT_W-1:0] young_fin, middle_fin, old_fin;
   logic [IDX_W+SLOT_W-1:0]  slot_ext;
   logic [CNT_W+COUNT_W-1:0] young_ext, middle_ext, old_ext;

   ksat_mem #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_mem (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_idx (free_idx_ff),
      .wr_key (key_ff),
      .wr_age (age_ff),
      .rd_idx (rd_idx_ff),
      .rd_key (mem_rd_key),
      .rd_age (mem_rd_age)
   );

   // during the scan the unit sees the slot just read; at the end it bins the age
   // that the command adds or removes
   assign cmp_used = used_ff[cmp_idx_ff];
   assign cmp_age  = finish_en ? ((cmd_ff == CMD_INSERT) ? age_ff : hit_age_ff) : mem_rd_age;

   ksat_cmp u_cmp (
      .used         (cmp_used),
      .slot_key     (mem_rd_key),
      .item_key     (key_ff),
      .age          (cmp_age),
      .young_limit  (young_limit_ff),
      .middle_limit (middle_limit_ff),
      .res          (cmp_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_idx_ff == LAST_IDX) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST:   state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      busy      = 1'b1;
      accept    = 1'b0;
      scan_en   = 1'b0;
      finish_en = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy   = 1'b0;
            accept = start;
         end
         ST_SCAN:   scan_en = 1'b1;
         ST_LAST:   ;
         ST_FINISH: finish_en = 1'b1;
         default:   ;
      endcase
   end

   // scan accumulation
   always_comb begin
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      age_in        = age_ff;
      rd_idx_in     = rd_idx_ff;
      cmp_vld_in    = scan_en;
      cmp_idx_in    = rd_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_age_in    = hit_age_ff;
      young_cnt_in  = young_cnt_ff;
      middle_cnt_in = middle_cnt_ff;
      old_cnt_in    = old_cnt_ff;

      if (accept) begin
         cmd_in        = req_cmd;
         key_in        = req_key;
         age_in        = req_age;
         rd_idx_in     = '0;
         free_found_in = 1'b0;
         free_idx_in   = '0;
         hit_found_in  = 1'b0;
         hit_idx_in    = '0;
         young_cnt_in  = '0;
         middle_cnt_in = '0;
         old_cnt_in    = '0;
      end

      if (scan_en) begin
         rd_idx_in = rd_idx_ff + 1'b1;
      end

      if (cmp_vld_ff) begin
         if (!cmp_used && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = cmp_idx_ff;
         end
         if (cmp_res.match && !hit_found_ff) begin
            hit_found_in = 1'b1;
            hit_idx_in   = cmp_idx_ff;
            hit_age_in   = mem_rd_age;
         end
         if (cmp_used) begin
            case (cmp_res.bin)
               BIN_YOUNG:  young_cnt_in  = young_cnt_ff + 1'b1;
               BIN_MIDDLE: middle_cnt_in = middle_cnt_ff + 1'b1;
               BIN_OLD:    old_cnt_in    = old_cnt_ff + 1'b1;
               default:    ;
            endcase
         end
      end
   end

   // write-back and result
   always_comb begin
      ins_done      = 1'b0;
      del_done      = 1'b0;
      res_idx       = '0;
      rsp_status_in = STATUS_DONE;
      used_in       = used_ff;

      if (cmd_ff == CMD_INSERT) begin
         if (!free_found_ff) begin
            rsp_status_in = STATUS_FULL;
         end else if (hit_found_ff) begin
            rsp_status_in = STATUS_DUP;
            res_idx       = hit_idx_ff;
         end else begin
            ins_done = 1'b1;
            res_idx  = free_idx_ff;
         end
      end else begin
         if (!hit_found_ff) begin
            rsp_status_in = STATUS_MISSING;
         end else begin
            del_done = 1'b1;
            res_idx  = hit_idx_ff;
         end
      end

      mem_wr_en = finish_en && ins_done;
      if (finish_en && ins_done) begin
         used_in[free_idx_ff] = 1'b1;
      end
      if (finish_en && del_done) begin
         used_in[hit_idx_ff] = 1'b0;
      end

      young_fin  = young_cnt_ff
                   + CNT_W'(ins_done && cmp_res.bin == BIN_YOUNG)
                   - CNT_W'(del_done && cmp_res.bin == BIN_YOUNG);
      middle_fin = middle_cnt_ff
                   + CNT_W'(ins_done && cmp_res.bin == BIN_MIDDLE)
                   - CNT_W'(del_done && cmp_res.bin == BIN_MIDDLE);
      old_fin    = old_cnt_ff
                   + CNT_W'(ins_done && cmp_res.bin == BIN_OLD)
                   - CNT_W'(del_done && cmp_res.bin == BIN_OLD);

      slot_ext   = {{SLOT_W{1'b0}}, res_idx};
      young_ext  = {{COUNT_W{1'b0}}, young_fin};
      middle_ext = {{COUNT_W{1'b0}}, middle_fin};
      old_ext    = {{COUNT_W{1'b0}}, old_fin};

      rsp_valid_in  = finish_en;
      rsp_slot_in   = slot_ext[SLOT_W-1:0];
      rsp_young_in  = young_ext[COUNT_W-1:0];
      rsp_middle_in = middle_ext[COUNT_W-1:0];
      rsp_old_in    = old_ext[COUNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         used_ff         <= '0;
         cmp_vld_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         young_limit_ff  <= YOUNG_LIMIT_RESET;
         middle_limit_ff <= MIDDLE_LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_YOUNG_LIMIT:  young_limit_ff  <= csr_wdata;
               CSR_MIDDLE_LIMIT: middle_limit_ff <= csr_wdata;
               default:          ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      age_ff        <= age_in;
      rd_idx_ff     <= rd_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      hit_age_ff    <= hit_age_in;
      young_cnt_ff  <= young_cnt_in;
      middle_cnt_ff <= middle_cnt_in;
      old_cnt_ff    <= old_cnt_in;
      if (finish_en) begin
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_young_ff  <= rsp_young_in;
         rsp_middle_ff <= rsp_middle_in;
         rsp_old_ff    <= rsp_old_in;
      end
   end

   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_young_count  = rsp_young_ff;
   assign rsp_middle_count = rsp_middle_ff;
   assign rsp_old_count    = rsp_old_ff;

`ifndef ASSERT_OFF
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while a command is still in flight");

   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_FINISH))
      else $error("result strobe not preceded by write-back");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not start a scan");

   a_bins_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |->
         ((CNT_W+2)'(young_cnt_ff) + (CNT_W+2)'(middle_cnt_ff)
          + (CNT_W+2)'(old_cnt_ff)) <= (CNT_W+2)'(ENTRIES))
      else $error("bin counts exceed table size");

   a_write_free_slot: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> !used_ff[free_idx_ff])
      else $error("insert overwrites a used slot");
`endif

endmodule

FILE: rtl/core/ksat_mem.sv
module ksat_mem
   import ksat_pkg::*;
#(
   parameter int ENTRIES = DEF_ENTRIES,
   parameter int IDX_W   = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  logic [KEY_W-1:0] wr_key,
   input  logic [AGE_W-1:0] wr_age,
   input  logic [IDX_W-1:0] rd_idx,
   output logic [KEY_W-1:0] rd_key,
   output logic [AGE_W-1:0] rd_age
);

   logic [KEY_W+AGE_W-1:0] mem [ENTRIES];
   logic [KEY_W+AGE_W-1:0] rd_word_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= {wr_key, wr_age};
      end
      rd_word_ff <= mem[rd_idx];
   end

   assign rd_key = rd_word_ff[KEY_W+AGE_W-1:AGE_W];
   assign rd_age = rd_word_ff[AGE_W-1:0];

endmodule

FILE: rtl/core/ksat_cmp.sv
module ksat_cmp
   import ksat_pkg::*;
(
   input  logic             used,
   input  logic [KEY_W-1:0] slot_key,
   input  logic [KEY_W-1:0] item_key,
   input  logic [AGE_W-1:0] age,
   input  logic [AGE_W-1:0] young_limit,
   input  logic [AGE_W-1:0] middle_limit,
   output cmp_res_type      res
);

   always_comb begin
      res.match = used && (slot_key == item_key);
      if (age <= young_limit) begin
         res.bin = BIN_YOUNG;
      end else if (age <= middle_limit) begin
         res.bin = BIN_MIDDLE;
      end else begin
         res.bin = BIN_OLD;
      end
   end

endmodule
